### sv/contiguous_complement_match_mask_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complement match mask block
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_COMPLEMENT_MATCH_MASK_ASSERT_SVH
`define CONTIGUOUS_COMPLEMENT_MATCH_MASK_ASSERT_SVH

// Same-cycle implication
`define CCMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ccmm_pkg.sv
// ----------------------------------------------------------------------------
// ccmm_pkg
// Types, sizes and the run-length helper shared by the match mask block.
// ----------------------------------------------------------------------------
package ccmm_pkg;

  localparam int POOL_SIZE = 16;
  localparam int WORD_BITS = 16;
  // Lanes that show up in the result mask
  localparam int MASK_BITS = (POOL_SIZE < 16) ? POOL_SIZE : 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  // bit k set when the word holds a run of at least k ones
  typedef logic [WORD_BITS:0]   run_flags_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic [15:0] entry_value;
    logic [15:0] receptor_word;
    logic [4:0]  receptor_threshold;
  } in_item_t;

  typedef struct packed {
    logic [15:0] match_mask;
    logic        no_match;
  } out_item_t;

  typedef struct packed {
    logic we;    // write the pool word
    logic adv1;  // capture receptor difference
    logic adv2;  // capture run flags
  } lane_ctl_t;

  // Window AND by doubling: w[k] bit b = AND of x[b +: k].
  function automatic run_flags_t run_flags(input word_t x);
    word_t      w [0:WORD_BITS];
    run_flags_t f;
    int         p;
    w[0] = '1;
    w[1] = x;
    for (int k = 2; k <= WORD_BITS; k++) begin
      p = 1;
      while (p * 2 < k) begin
        p = p * 2;
      end
      w[k] = w[p] & (w[k-p] >> p);
    end
    for (int k = 0; k <= WORD_BITS; k++) begin
      f[k] = |w[k];
    end
    return f;
  endfunction

endpackage

### sv/ccmm_lane.sv
// ----------------------------------------------------------------------------
// ccmm_lane
// One pool slot: stored ligand word, receptor difference and run flags.
// ----------------------------------------------------------------------------
module ccmm_lane import ccmm_pkg::*; (
  input  logic       clk,
  input  lane_ctl_t  ctl,
  input  word_t      wr_word,
  input  word_t      rec_word,
  output run_flags_t flags
);

  word_t      pool_word_r;
  word_t      diff_r;
  run_flags_t flags_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      pool_word_r <= wr_word;
    end
    // complementary bits
    if (ctl.adv1) begin
      diff_r <= pool_word_r ^ rec_word;
    end
    if (ctl.adv2) begin
      flags_r <= run_flags(diff_r);
    end
  end

  assign flags = flags_r;

endmodule

### sv/contiguous_complement_match_mask.sv
// ----------------------------------------------------------------------------
// contiguous_complement_match_mask
// r-contiguous-bits matching of a receptor word against a pool of ligands.
// ----------------------------------------------------------------------------
// A load item writes one pool slot in the cycle it is accepted and gives no
// result. A query item is scored against all pool slots in parallel, one lane
// per slot, through three register stages: the receptor difference (XOR), the
// per-length run flags of that difference, and the result register that picks
// the flag for the threshold and folds the lanes into match_mask and no_match.
// The block takes one item per cycle while in_ready is high. Each stage
// advances on its own, so bubbles close up and a stall on the result side
// only backs up the stages behind it. A query sees every load accepted
// before it. Slots never loaded give undefined bits. The user must write
// active_r through cfg_we only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module contiguous_complement_match_mask import ccmm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [4:0] cfg_wdata
);

  `include "contiguous_complement_match_mask_assert.svh"

  logic        cfg_active_r;
  logic [4:0]  active_r;
  logic        v1_r, v1_nxt;
  logic        v2_r, v2_nxt;
  logic        v3_r, v3_nxt;
  logic [4:0]  thr1_r, thr2_r;
  out_item_t   out_r, out_nxt;
  logic        rdy1, rdy2, rdy3;
  logic        accept, q_accept, l_accept;
  word_t       wr_word, rec_word;
  lane_ctl_t   lane_ctl [POOL_SIZE];
  run_flags_t  lane_flags [POOL_SIZE];
  logic        any_bind;

  // Hold the active count; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      cfg_active_r <= 1'b0;
    end else if (cfg_we) begin
      active_r     <= cfg_wdata;
      cfg_active_r <= 1'b1;
    end
  end

  // Per-stage ready: a stage can take new data when empty or draining
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign accept   = in_valid && in_ready;
  assign q_accept = accept && (in_data.kind == KIND_QUERY);
  assign l_accept = accept && (in_data.kind == KIND_LOAD);

  assign wr_word  = WORD_BITS'(in_data.entry_value);
  assign rec_word = WORD_BITS'(in_data.receptor_word);

  // Drive lane enables; loads beyond the pool are dropped
  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      lane_ctl[i].we   = l_accept && (32'(in_data.entry_index) == i);
      lane_ctl[i].adv1 = q_accept;
      lane_ctl[i].adv2 = rdy2 && v1_r;
    end
  end

  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_lane
    ccmm_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl[g]),
      .wr_word  (wr_word),
      .rec_word (rec_word),
      .flags    (lane_flags[g])
    );
  end

  // Pick each lane's flag for the threshold and fold into the result
  always_comb begin
    logic hit;
    out_nxt  = '0;
    any_bind = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      hit = 1'b0;
      for (int k = 0; k <= WORD_BITS; k++) begin
        if (32'(thr2_r) == k) begin
          hit = lane_flags[i][k];
        end
      end
      // inactive lanes never bind
      if (32'(active_r) <= i) begin
        hit = 1'b0;
      end
      if (i < MASK_BITS) begin
        out_nxt.match_mask[i] = hit;
      end
      any_bind = any_bind | hit;
    end
    out_nxt.no_match = !any_bind;
  end

  always_comb begin
    v1_nxt = rdy1 ? q_accept : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Threshold travels with the item; result held until taken
  always_ff @(posedge clk) begin
    if (q_accept) begin
      thr1_r <= in_data.receptor_threshold;
    end
    if (rdy2 && v1_r) begin
      thr2_r <= thr1_r;
    end
    if (rdy3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

  // A load never enters the scoring pipeline
  `CCMM_ASSERT_NEXT(a_load_no_result, l_accept && rdy1, !v1_r, "load item entered the pipeline")

  // With every lane shown in the mask, no_match is the empty mask
  `CCMM_ASSERT_NOW(a_nomatch_mask, v3_r && (POOL_SIZE <= 16), out_r.no_match == (out_r.match_mask == '0), "no_match disagrees with match_mask")

  // Lanes at or above the active count stay clear
  `CCMM_ASSERT_NOW(a_inactive_clear, v3_r && (active_r < 5'd16), (out_r.match_mask >> active_r) == '0, "inactive lane set in match_mask")

  // Pool with no active entries never binds
  `CCMM_ASSERT_NOW(a_empty_pool, v3_r && cfg_active_r && (active_r == '0), out_r.no_match, "empty pool reported a match")

endmodule
